// ----- hdl/bcdv_pkg.sv -----
package bcdv_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned COUNT_W = 5;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0]  CHAR_SPACE = 8'h20;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 5'd31;

  localparam logic [COUNT_W-1:0] LEN_EAN8  = 5'd8;
  localparam logic [COUNT_W-1:0] LEN_EAN13 = 5'd13;
  localparam logic [COUNT_W-1:0] LEN_GTIN14 = 5'd14;
  localparam logic [COUNT_W-1:0] LEN_SSCC16 = 5'd16;

  localparam logic [DIGIT_W-1:0] MODULUS = 4'd10;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_LENGTH = 2'd1,
    ST_BAD_CHECK  = 2'd2,
    ST_BAD_CHAR   = 2'd3
  } status_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] even_sum;
    logic [DIGIT_W-1:0] odd_sum;
    logic [DIGIT_W-1:0] pending_digit;
    logic [COUNT_W-1:0] char_count;
    logic               space_seen;
    logic               bad_char_seen;
  } acc_t;

  function automatic logic [DIGIT_W-1:0] add_mod10(input logic [DIGIT_W-1:0] a,
                                                   input logic [DIGIT_W-1:0] b);
    logic [DIGIT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MODULUS}) begin
      s = s - {1'b0, MODULUS};
    end
    return s[DIGIT_W-1:0];
  endfunction

endpackage

// ----- hdl/bcdv_accum.sv -----
module bcdv_accum (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         consume,
  input  logic                         last_char,
  input  logic [bcdv_pkg::CHAR_W-1:0]  char_code,
  output bcdv_pkg::acc_t               upd
);

  bcdv_pkg::acc_t acc;

  logic                           is_digit;
  logic [bcdv_pkg::CHAR_W-1:0]    offset;
  logic [bcdv_pkg::DIGIT_W-1:0]   digit;
  logic [bcdv_pkg::COUNT_W-1:0]   pos;

  assign is_digit = (char_code >= bcdv_pkg::CHAR_ZERO) && (char_code <= bcdv_pkg::CHAR_NINE);
  assign offset   = char_code - bcdv_pkg::CHAR_ZERO;
  assign digit    = is_digit ? offset[bcdv_pkg::DIGIT_W-1:0] : '0;
  assign pos      = acc.char_count - 5'd1;

  always_comb begin
    upd = acc;
    if (!acc.space_seen) begin
      if (char_code == bcdv_pkg::CHAR_SPACE) begin
        upd.space_seen = 1'b1;
      end else begin
        if (!is_digit) begin
          upd.bad_char_seen = 1'b1;
        end
        if (acc.char_count != '0) begin
          if (!pos[0]) begin
            upd.even_sum = bcdv_pkg::add_mod10(acc.even_sum, acc.pending_digit);
          end else begin
            upd.odd_sum = bcdv_pkg::add_mod10(acc.odd_sum, acc.pending_digit);
          end
        end
        upd.pending_digit = digit;
        if (acc.char_count != bcdv_pkg::COUNT_MAX) begin
          upd.char_count = acc.char_count + 5'd1;
        end
      end
    end
  end

  // clear after the last beat of a code
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (consume) begin
      if (last_char) begin
        acc <= '0;
      end else begin
        acc <= upd;
      end
    end
  end

endmodule

// ----- hdl/bcdv_check.sv -----
module bcdv_check (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  bcdv_pkg::acc_t upd,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata    // code_valid, check_status[1:0], code_length[4:0]
);

  logic [bcdv_pkg::DIGIT_W-1:0] w3;
  logic [bcdv_pkg::DIGIT_W-1:0] w1;
  logic [5:0]                   weighted;
  logic [5:0]                   total;
  logic [bcdv_pkg::DIGIT_W-1:0] check_digit;
  logic                         length_ok;
  bcdv_pkg::status_t            status;
  logic [7:0]                   data_next;

  assign w3       = upd.char_count[0] ? upd.odd_sum : upd.even_sum;
  assign w1       = upd.char_count[0] ? upd.even_sum : upd.odd_sum;
  assign weighted = {1'b0, w3, 1'b0} + {2'b00, w3} + {2'b00, w1};

  always_comb begin
    priority if (weighted >= 6'd30) begin
      total = weighted - 6'd30;
    end else if (weighted >= 6'd20) begin
      total = weighted - 6'd20;
    end else if (weighted >= 6'd10) begin
      total = weighted - 6'd10;
    end else begin
      total = weighted;
    end
  end

  assign check_digit = (total == '0) ? '0 : (bcdv_pkg::MODULUS - total[3:0]);

  assign length_ok = (upd.char_count == bcdv_pkg::LEN_EAN8)
                  || (upd.char_count == bcdv_pkg::LEN_EAN13)
                  || (upd.char_count == bcdv_pkg::LEN_GTIN14)
                  || (upd.char_count == bcdv_pkg::LEN_SSCC16);

  always_comb begin
    priority if (upd.bad_char_seen) begin
      status = bcdv_pkg::ST_BAD_CHAR;
    end else if (!length_ok) begin
      status = bcdv_pkg::ST_BAD_LENGTH;
    end else if (upd.pending_digit != check_digit) begin
      status = bcdv_pkg::ST_BAD_CHECK;
    end else begin
      status = bcdv_pkg::ST_OK;
    end
  end

  assign data_next = {upd.char_count, status, (status == bcdv_pkg::ST_OK)};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= data_next;
    end
  end

endmodule

// ----- hdl/barcode_check_digit_validator_top.sv -----
// Flow: a beat is registered at the input, then folded into the running sums;
//   a last beat loads the result register and raises m_tvalid once that register is free.
// Throughput: one character per cycle through the input register and the
//   combinational mod-10 fold; a full result register stalls only last beats.
// Reset: rst is synchronous, active high; clears sums, count, flags and both valids.
module barcode_check_digit_validator_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // char_code[7:0]
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata     // code_valid, check_status[1:0], code_length[4:0]
);

  logic                         in_valid;
  logic [bcdv_pkg::CHAR_W-1:0]  in_char;
  logic                         in_last;
  logic                         out_free;
  logic                         consume;
  bcdv_pkg::acc_t               upd;

  assign out_free = !m_tvalid || m_tready;
  assign consume  = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  bcdv_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .consume   (consume),
    .last_char (in_last),
    .char_code (in_char),
    .upd       (upd)
  );

  bcdv_check u_check (
    .clk      (clk),
    .rst      (rst),
    .load     (consume && in_last),
    .upd      (upd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- verif/barcode_check_digit_validator_top_tb.sv -----
module barcode_check_digit_validator_top_tb;

  typedef struct {
    logic              code_valid;
    bcdv_pkg::status_t status;
    logic [4:0]        length;
  } scan_result_t;

  typedef struct {
    logic [7:0]   char_code;
    logic         last_char;
    bit           typed;
    scan_result_t result;
  } scan_row_t;

  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_CHARS = 1280;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  barcode_check_digit_validator_top DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  scan_result_t expected_results[$];
  scan_row_t    directed_rows[$];

  logic [3:0] even_acc;
  logic [3:0] odd_acc;
  logic [3:0] held_digit;
  logic [4:0] scan_len;
  bit         code_ended;
  bit         saw_bad_char;

  bit           beat_typed = 1'b0;
  scan_result_t beat_result;

  int send_idle_pct = 31;
  int recv_idle_pct = 64;
  int chars_sent = 0;
  int error_count = 0;
  int results_checked = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int stall_cycles = 0;

  task automatic clear_scan();
    even_acc = '0;
    odd_acc = '0;
    held_digit = '0;
    scan_len = '0;
    code_ended = 1'b0;
    saw_bad_char = 1'b0;
  endtask

  task automatic scan_char(input logic [7:0] c, input logic l,
                           output bit emits, output scan_result_t r);
    logic [3:0] d;
    logic [3:0] w3;
    logic [3:0] w1;
    int         total;
    int         check;
    emits = 1'b0;
    r.code_valid = 1'b0;
    r.status = bcdv_pkg::ST_OK;
    r.length = '0;
    if (!code_ended) begin
      if (c == bcdv_pkg::CHAR_SPACE) begin
        code_ended = 1'b1;
      end else begin
        if (c >= bcdv_pkg::CHAR_ZERO && c <= bcdv_pkg::CHAR_NINE) begin
          d = 4'(c - bcdv_pkg::CHAR_ZERO);
        end else begin
          d = '0;
          saw_bad_char = 1'b1;
        end
        if (scan_len != 0) begin
          if (scan_len[0]) even_acc = 4'((int'(even_acc) + int'(held_digit)) % 10);
          else odd_acc = 4'((int'(odd_acc) + int'(held_digit)) % 10);
        end
        held_digit = d;
        if (scan_len != bcdv_pkg::COUNT_MAX) scan_len = scan_len + 1'b1;
      end
    end
    if (l) begin
      w3 = scan_len[0] ? odd_acc : even_acc;
      w1 = scan_len[0] ? even_acc : odd_acc;
      total = (3 * int'(w3) + int'(w1)) % 10;
      check = (total != 0) ? 10 - total : 0;
      if (saw_bad_char) r.status = bcdv_pkg::ST_BAD_CHAR;
      else if (!(scan_len inside {bcdv_pkg::LEN_EAN8, bcdv_pkg::LEN_EAN13,
                                  bcdv_pkg::LEN_GTIN14, bcdv_pkg::LEN_SSCC16}))
        r.status = bcdv_pkg::ST_BAD_LENGTH;
      else if (int'(held_digit) != check) r.status = bcdv_pkg::ST_BAD_CHECK;
      else r.status = bcdv_pkg::ST_OK;
      r.code_valid = (r.status == bcdv_pkg::ST_OK);
      r.length = scan_len;
      emits = 1'b1;
      clear_scan();
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  task automatic send_char(input logic [7:0] c, input logic l, input bit typed,
                           input scan_result_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= l;
    beat_typed <= typed;
    beat_result <= r;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic add_row(input logic [7:0] c, input logic l, input bit typed,
                         input logic v, input bcdv_pkg::status_t st,
                         input logic [4:0] len);
    scan_row_t row;
    row.char_code = c;
    row.last_char = l;
    row.typed = typed;
    row.result.code_valid = v;
    row.result.status = st;
    row.result.length = len;
    directed_rows.push_back(row);
  endtask

  task automatic add_digits(input string s, input bit last_on_end);
    for (int i = 0; i < s.len(); i++)
      add_row(s[i], last_on_end && (i == s.len() - 1), 1'b0, 1'b0, bcdv_pkg::ST_OK, '0);
  endtask

  function automatic logic [7:0] random_non_digit();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while ((c >= bcdv_pkg::CHAR_ZERO && c <= bcdv_pkg::CHAR_NINE) ||
           c == bcdv_pkg::CHAR_SPACE)
      c = 8'($urandom_range(255));
    return c;
  endfunction

  task automatic send_code(input int len, input bit good_check, input bit bad_char,
                           input bit end_space, input bit noise);
    logic [7:0]   chars[$];
    int           digits[];
    int           total;
    int           junk;
    int           pos;
    scan_result_t none;
    none.code_valid = 1'b0;
    none.status = bcdv_pkg::ST_OK;
    none.length = '0;
    digits = new[len];
    total = 0;
    foreach (digits[i]) digits[i] = $urandom_range(9);
    if (good_check && len > 0) begin
      for (int i = 0; i < len - 1; i++)
        total += digits[i] * ((((len - 2 - i) % 2) == 0) ? 3 : 1);
      total = total % 10;
      digits[len - 1] = (total != 0) ? 10 - total : 0;
    end
    foreach (digits[i]) chars.push_back(bcdv_pkg::CHAR_ZERO + 8'(digits[i]));
    if (noise) begin
      foreach (chars[i]) chars[i] = 8'($urandom_range(255));
    end
    if (bad_char && len > 0) begin
      pos = $urandom_range(len - 1);
      chars[pos] = random_non_digit();
    end
    if (end_space || len == 0) begin
      chars.push_back(bcdv_pkg::CHAR_SPACE);
      junk = $urandom_range(3);
      repeat (junk) chars.push_back(8'($urandom_range(255)));
    end
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1, 1'b0, none);
  endtask

  always @(negedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    bit           emits;
    scan_result_t predicted;
    scan_result_t want;
    scan_result_t got;
    if (rst) begin
      clear_scan();
    end else begin
      if (s_tvalid && s_tready) begin
        scan_char(s_tdata, s_tlast, emits, predicted);
        if (emits) expected_results.push_back(beat_typed ? beat_result : predicted);
      end
      if (m_tvalid && m_tready) begin
        got.code_valid = m_tdata[0];
        got.status = bcdv_pkg::status_t'(m_tdata[2:1]);
        got.length = m_tdata[7:3];
        if (expected_results.size() == 0) begin
          report_mismatch("results pending", 1, 0);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          status_seen[int'(want.status)]++;
          if (got.code_valid !== want.code_valid)
            report_mismatch("code_valid", got.code_valid, want.code_valid);
          if (got.status !== want.status)
            report_mismatch("check_status", int'(got.status), int'(want.status));
          if (got.length !== want.length)
            report_mismatch("code_length", got.length, want.length);
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    int len;
    int lens[4];
    lens = '{8, 13, 14, 16};

    add_row(bcdv_pkg::CHAR_SPACE, 1'b1, 1'b1, 1'b0, bcdv_pkg::ST_BAD_LENGTH, 5'd0);
    add_digits("96385074", 1'b1);
    add_row(8'hFF, 1'b1, 1'b1, 1'b0, bcdv_pkg::ST_BAD_CHAR, 5'd1);
    add_row(8'h00, 1'b1, 1'b1, 1'b0, bcdv_pkg::ST_BAD_CHAR, 5'd1);
    add_digits("53", 1'b0);
    add_row(bcdv_pkg::CHAR_SPACE, 1'b0, 1'b0, 1'b0, bcdv_pkg::ST_OK, '0);
    add_row("x", 1'b1, 1'b0, 1'b0, bcdv_pkg::ST_OK, '0);
    add_digits("1234567", 1'b0);
    add_row(bcdv_pkg::CHAR_SPACE, 1'b1, 1'b0, 1'b0, bcdv_pkg::ST_OK, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_char(directed_rows[i].char_code, directed_rows[i].last_char,
                directed_rows[i].typed, directed_rows[i].result);

    while (chars_sent < RANDOM_CHARS) begin
      if (chars_sent < RANDOM_CHARS / 3) begin
        send_idle_pct = 31;
        recv_idle_pct = 64;
      end else if (chars_sent < 2 * RANDOM_CHARS / 3) begin
        send_idle_pct = 64;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = lens[$urandom_range(3)];
        send_code(len, $urandom_range(99) < 60, 1'b0, $urandom_range(99) < 15, 1'b0);
      end else if (pick < 85) begin
        send_code($urandom_range(40), $urandom_range(1), 1'b0, $urandom_range(1), 1'b0);
      end else if (pick < 95) begin
        len = lens[$urandom_range(3)];
        send_code(len, 1'b1, 1'b1, $urandom_range(1), 1'b0);
      end else begin
        send_code($urandom_range(1, 20), 1'b0, 1'b0, $urandom_range(1), 1'b1);
      end
    end
    s_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d characters, checked %0d results", chars_sent, results_checked);
    $display("Status mix: ok %0d, bad length %0d, bad check %0d, bad char %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/bcdv_pkg.sv
hdl/bcdv_accum.sv
hdl/bcdv_check.sv
hdl/barcode_check_digit_validator_top.sv
verif/barcode_check_digit_validator_top_tb.sv
